>>> rtl/core/vrcw_pkg.sv
// ----------------------------------------------------------------------------
// vrcw_pkg
// shared types and constants of the voxel ray cell walker
// ----------------------------------------------------------------------------
package vrcw_pkg;

    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned AXIS_W    = 2;
    localparam int unsigned EYE_W     = 32;
    localparam int unsigned DIR_W     = 16;
    localparam int unsigned CELL_W    = 16;
    localparam int unsigned SIDE_W    = 32;
    localparam int unsigned REACH_W   = 16;
    localparam int unsigned FRAC_W    = 17;
    localparam int unsigned DIV_CNT_W = 4;
    localparam int unsigned IN_W      = 3 * EYE_W + 3 * DIR_W;
    localparam int unsigned OUT_W     = 3 * CELL_W;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [AXIS_W-1:0]    AXIS_X      = 2'd0;
    localparam logic [AXIS_W-1:0]    AXIS_Y      = 2'd1;
    localparam logic [AXIS_W-1:0]    AXIS_Z      = 2'd2;
    localparam logic [SIDE_W-1:0]    SAT32       = 32'hFFFF_FFFF;
    localparam logic [REACH_W-1:0]   REACH_RESET = 16'd1024;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 4'd15;
    localparam logic [FRAC_W-1:0]    ONE_CELL    = 17'h1_0000;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b000_0001,
        ST_SETUP = 7'b000_0010,
        ST_DIV   = 7'b000_0100,
        ST_MUL   = 7'b000_1000,
        ST_CHECK = 7'b001_0000,
        ST_STEP  = 7'b010_0000,
        ST_EMIT  = 7'b100_0000
    } t_state;

endpackage

>>> rtl/core/voxel_ray_cell_walker_core.sv
// ----------------------------------------------------------------------------
// voxel_ray_cell_walker_core
// walks the grid cells pierced by a ray, one shared divider and stepper
// ----------------------------------------------------------------------------
// channel   | dir | handshake                 | payload
// ----------+-----+---------------------------+-------------------------------
// ray in    | in  | s_tvalid / s_tready       | s_tdata: eye x,y,z, dir x,y,z
// cell out  | out | m_tvalid / m_tready       | m_tdata: cell x,y,z, tlast, tuser
// config    | in  | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// a ray takes a setup step per axis, plus radix-4 divide steps and a
// multiply step for each nonzero direction component
// then a check step, and a step and an emit step per emitted cell
// the divider and the compare-add stepper are each one unit reused per axis
// reset is synchronous active low and restores reach_distance to 4.0 cells
// a stalled output holds the walker in its emit step; the next ray is taken
// in the cycle after the last cell request is loaded
// ----------------------------------------------------------------------------
module voxel_ray_cell_walker_core #(
    parameter int unsigned MAX_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // eye_x, eye_y, eye_z (32 each), dir_x, dir_y, dir_z (16 each)
    input  logic [vrcw_pkg::IN_W-1:0]           s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_x, cell_y, cell_z (16 each)
    output logic [vrcw_pkg::OUT_W-1:0]          m_tdata,
    output logic                                m_tlast,
    // no_cell
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vrcw_pkg::PADDR_W-1:0]        paddr,
    input  logic [vrcw_pkg::PDATA_W-1:0]        pwdata,
    output logic [vrcw_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);

    vrcw_pkg::t_state                     r_state, n_state;
    logic [vrcw_pkg::REACH_W-1:0]         r_reach;
    logic [vrcw_pkg::EYE_W-1:0]           r_eye   [vrcw_pkg::NUM_AXES];
    logic [vrcw_pkg::DIR_W-1:0]           r_dir   [vrcw_pkg::NUM_AXES];
    logic [vrcw_pkg::CELL_W-1:0]          r_cell  [vrcw_pkg::NUM_AXES];
    logic [vrcw_pkg::SIDE_W-1:0]          r_side  [vrcw_pkg::NUM_AXES];
    logic [vrcw_pkg::SIDE_W-1:0]          r_delta [vrcw_pkg::NUM_AXES];
    logic                                 r_sign  [vrcw_pkg::NUM_AXES];
    logic [vrcw_pkg::AXIS_W-1:0]          r_axis;
    logic [CNT_W-1:0]                     r_count;
    logic [vrcw_pkg::DIR_W-1:0]           r_rem;
    logic [vrcw_pkg::SIDE_W-1:0]          r_quot;
    logic [vrcw_pkg::DIV_CNT_W-1:0]       r_div_cnt;
    logic                                 r_out_valid;
    logic [vrcw_pkg::OUT_W-1:0]           r_out_data;
    logic                                 r_out_last;
    logic                                 r_out_user;

    logic                                 in_fire;
    logic                                 cfg_wr;
    logic                                 slot_free;
    logic                                 out_load;
    logic [vrcw_pkg::OUT_W-1:0]           out_data;
    logic                                 out_last;
    logic                                 out_user;

    logic [vrcw_pkg::EYE_W-1:0]           cur_eye;
    logic [vrcw_pkg::DIR_W-1:0]           cur_dir;
    logic [vrcw_pkg::DIR_W-1:0]           cur_mag;
    logic                                 cur_pos;
    logic [vrcw_pkg::FRAC_W-1:0]          cur_frac;
    logic [vrcw_pkg::FRAC_W+30:0]         prod;

    logic [vrcw_pkg::DIR_W:0]             div_t1, div_t2;
    logic                                 div_q1, div_q2;
    logic [vrcw_pkg::DIR_W-1:0]           div_r1, div_r2;

    logic [vrcw_pkg::SIDE_W-1:0]          min01, side_min;
    logic                                 may_cont;
    logic [vrcw_pkg::AXIS_W-1:0]          step_ax;
    logic [vrcw_pkg::SIDE_W:0]            step_sum;
    logic [vrcw_pkg::SIDE_W-1:0]          step_side;
    logic [vrcw_pkg::CELL_W-1:0]          step_cell;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (r_state == vrcw_pkg::ST_IDLE);
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? '0 : {{(vrcw_pkg::PDATA_W - vrcw_pkg::REACH_W){1'b0}}, r_reach};

    // per-axis setup
    assign cur_eye  = r_eye[r_axis];
    assign cur_dir  = r_dir[r_axis];
    assign cur_mag  = cur_dir[vrcw_pkg::DIR_W-1] ? (~cur_dir + 16'd1) : cur_dir;
    assign cur_pos  = !cur_dir[vrcw_pkg::DIR_W-1] && (cur_dir != '0);
    assign cur_frac = cur_pos ? (vrcw_pkg::ONE_CELL - {1'b0, cur_eye[15:0]})
                              : {1'b0, cur_eye[15:0]};
    assign prod     = cur_frac * r_quot[30:0];

    // radix-4 restoring divide of 2^30 by the magnitude
    always_comb begin
        div_t1 = {r_rem, 1'b0};
        div_q1 = (div_t1 >= {1'b0, cur_mag});
        div_r1 = div_q1 ? 16'(div_t1 - {1'b0, cur_mag}) : div_t1[15:0];
        div_t2 = {div_r1, (r_div_cnt == '0)};
        div_q2 = (div_t2 >= {1'b0, cur_mag});
        div_r2 = div_q2 ? 16'(div_t2 - {1'b0, cur_mag}) : div_t2[15:0];
    end

    // walk test and axis choice
    always_comb begin
        min01    = (r_side[1] < r_side[0]) ? r_side[1] : r_side[0];
        side_min = (r_side[2] < min01) ? r_side[2] : min01;
        may_cont = (side_min < {8'd0, r_reach, 8'd0}) && (r_count < CNT_W'(MAX_STEPS));
        if (r_side[0] < r_side[1] && r_side[0] < r_side[2]) begin
            step_ax = vrcw_pkg::AXIS_X;
        end else if (r_side[1] < r_side[2]) begin
            step_ax = vrcw_pkg::AXIS_Y;
        end else begin
            step_ax = vrcw_pkg::AXIS_Z;
        end
        step_sum  = {1'b0, r_side[step_ax]} + {1'b0, r_delta[step_ax]};
        step_side = step_sum[vrcw_pkg::SIDE_W] ? vrcw_pkg::SAT32
                                              : step_sum[vrcw_pkg::SIDE_W-1:0];
        step_cell = r_sign[step_ax] ? (r_cell[step_ax] - 16'd1) : (r_cell[step_ax] + 16'd1);
    end

    assign slot_free = !r_out_valid || m_tready;

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        out_data = {r_cell[2], r_cell[1], r_cell[0]};
        out_last = !may_cont;
        out_user = 1'b0;
        case (r_state)
            vrcw_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = vrcw_pkg::ST_SETUP;
                end
            end
            vrcw_pkg::ST_SETUP: begin
                if (cur_mag == '0) begin
                    n_state = (r_axis == vrcw_pkg::AXIS_Z) ? vrcw_pkg::ST_CHECK
                                                           : vrcw_pkg::ST_SETUP;
                end else begin
                    n_state = vrcw_pkg::ST_DIV;
                end
            end
            vrcw_pkg::ST_DIV: begin
                if (r_div_cnt == vrcw_pkg::DIV_LAST) begin
                    n_state = vrcw_pkg::ST_MUL;
                end
            end
            vrcw_pkg::ST_MUL: begin
                n_state = (r_axis == vrcw_pkg::AXIS_Z) ? vrcw_pkg::ST_CHECK
                                                       : vrcw_pkg::ST_SETUP;
            end
            vrcw_pkg::ST_CHECK: begin
                if (may_cont) begin
                    n_state = vrcw_pkg::ST_STEP;
                end else if (slot_free) begin
                    out_load = 1'b1;
                    out_data = '0;
                    out_last = 1'b1;
                    out_user = 1'b1;
                    n_state  = vrcw_pkg::ST_IDLE;
                end
            end
            vrcw_pkg::ST_STEP: begin
                n_state = vrcw_pkg::ST_EMIT;
            end
            vrcw_pkg::ST_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = may_cont ? vrcw_pkg::ST_STEP : vrcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vrcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vrcw_pkg::ST_IDLE;
            r_reach     <= vrcw_pkg::REACH_RESET;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_axis      <= vrcw_pkg::AXIS_X;
            r_div_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_reach <= pwdata[vrcw_pkg::REACH_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                vrcw_pkg::ST_IDLE: begin
                    r_axis  <= vrcw_pkg::AXIS_X;
                    r_count <= '0;
                end
                vrcw_pkg::ST_SETUP: begin
                    r_div_cnt <= '0;
                    if (cur_mag == '0 && r_axis != vrcw_pkg::AXIS_Z) begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                vrcw_pkg::ST_DIV: begin
                    r_div_cnt <= r_div_cnt + 4'd1;
                end
                vrcw_pkg::ST_MUL: begin
                    if (r_axis != vrcw_pkg::AXIS_Z) begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                vrcw_pkg::ST_STEP: begin
                    r_count <= r_count + CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_eye[0] <= s_tdata[31:0];
            r_eye[1] <= s_tdata[63:32];
            r_eye[2] <= s_tdata[95:64];
            r_dir[0] <= s_tdata[111:96];
            r_dir[1] <= s_tdata[127:112];
            r_dir[2] <= s_tdata[143:128];
        end
        case (r_state)
            vrcw_pkg::ST_SETUP: begin
                r_cell[r_axis] <= cur_eye[31:16];
                r_sign[r_axis] <= !cur_pos;
                r_rem          <= '0;
                r_quot         <= '0;
                if (cur_mag == '0) begin
                    r_delta[r_axis] <= vrcw_pkg::SAT32;
                    r_side[r_axis]  <= vrcw_pkg::SAT32;
                end
            end
            vrcw_pkg::ST_DIV: begin
                r_rem  <= div_r2;
                r_quot <= {r_quot[29:0], div_q1, div_q2};
            end
            vrcw_pkg::ST_MUL: begin
                r_delta[r_axis] <= r_quot;
                r_side[r_axis]  <= prod[47:16];
            end
            vrcw_pkg::ST_STEP: begin
                r_cell[step_ax] <= step_cell;
                r_side[step_ax] <= step_side;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data <= out_data;
            r_out_last <= out_last;
            r_out_user <= out_user;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tlast  = r_out_last;
    assign m_tuser  = r_out_user;

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("walker state not one-hot");

    a_empty_ray_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("empty ray request without last flag or with coordinates");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_STEPS))
        else $error("cell count beyond step limit");

    a_rem_below_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vrcw_pkg::ST_DIV) |-> (r_rem < cur_mag))
        else $error("divider remainder out of range");

    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == vrcw_pkg::ST_SETUP) && (r_axis == vrcw_pkg::AXIS_X))
        else $error("ray accepted without starting setup on x");
`endif

endmodule

>>> test/tb_voxel_ray_cell_walker_core.sv
// ----------------------------------------------------------------------------
// tb_voxel_ray_cell_walker_core
// self-checking bench for the voxel ray cell walker: rays go in on the
// slave stream, a local grid-walk predictor builds the expected cell list
// per ray, and every cell request on the master stream is checked in order
// against it, with random stalls on both streams and several reach settings
// ----------------------------------------------------------------------------
module tb_voxel_ray_cell_walker_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_STEPS = 16;
    localparam logic [vrcw_pkg::PADDR_W-1:0] REG_REACH  = 3'd0;
    localparam logic [vrcw_pkg::PADDR_W-1:0] REG_SPARE  = 3'd4;

    typedef struct packed {
        logic [vrcw_pkg::CELL_W-1:0] x;
        logic [vrcw_pkg::CELL_W-1:0] y;
        logic [vrcw_pkg::CELL_W-1:0] z;
        logic                        last;
        logic                        none;
    } t_cell_rec;

    logic                           i_clk;
    logic                           i_rst_n;
    logic [vrcw_pkg::IN_W-1:0]      s_tdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [vrcw_pkg::OUT_W-1:0]     m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [vrcw_pkg::PADDR_W-1:0]   paddr;
    logic [vrcw_pkg::PDATA_W-1:0]   pwdata;
    logic [vrcw_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    t_cell_rec                      cells_due[$];
    logic [vrcw_pkg::REACH_W-1:0]   reach_cfg;
    logic                           idle_on;
    int                             fail_count;

    voxel_ray_cell_walker_core #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic logic walk_open(input logic [2:0][vrcw_pkg::SIDE_W-1:0] side,
                                       input int count);
        logic [vrcw_pkg::SIDE_W-1:0] lo;
        lo = side[vrcw_pkg::AXIS_X];
        if (side[vrcw_pkg::AXIS_Y] < lo) lo = side[vrcw_pkg::AXIS_Y];
        if (side[vrcw_pkg::AXIS_Z] < lo) lo = side[vrcw_pkg::AXIS_Z];
        return (lo < {8'd0, reach_cfg, 8'd0}) && (count < MAX_STEPS);
    endfunction

    // grid walk of one ray, pushes every expected cell request
    task automatic predict_walk(input logic [2:0][vrcw_pkg::EYE_W-1:0] eye,
                                input logic [2:0][vrcw_pkg::DIR_W-1:0] dir);
        logic [2:0][vrcw_pkg::CELL_W-1:0] walk_pos;
        logic [2:0][vrcw_pkg::SIDE_W-1:0] side;
        logic [2:0][vrcw_pkg::SIDE_W-1:0] delta;
        logic [2:0]                       step_down;
        logic [16:0]                      mag;
        logic [16:0]                      frac;
        logic [63:0]                      prod;
        logic [32:0]                      sum;
        logic                             pos;
        logic [vrcw_pkg::AXIS_W-1:0]      ax;
        int                               count;
        t_cell_rec                        rec;
        for (int a = 0; a < vrcw_pkg::NUM_AXES; a++) begin
            walk_pos[a] = eye[a][31:16];
            pos = !dir[a][15] && (dir[a] != '0);
            mag = dir[a][15] ? (17'h1_0000 - {1'b0, dir[a]}) : {1'b0, dir[a]};
            step_down[a] = !pos;
            if (mag == '0) begin
                delta[a] = vrcw_pkg::SAT32;
                side[a] = vrcw_pkg::SAT32;
            end else begin
                delta[a] = 32'h4000_0000 / {15'd0, mag};
                frac = pos ? (vrcw_pkg::ONE_CELL - {1'b0, eye[a][15:0]})
                           : {1'b0, eye[a][15:0]};
                prod = ({47'd0, frac} * {32'd0, delta[a]}) >> 16;
                side[a] = (prod > {32'd0, vrcw_pkg::SAT32}) ? vrcw_pkg::SAT32 : prod[31:0];
            end
        end
        count = 0;
        if (!walk_open(side, count)) begin
            rec = '{x: '0, y: '0, z: '0, last: 1'b1, none: 1'b1};
            cells_due.push_back(rec);
        end else begin
            while (walk_open(side, count)) begin
                if (side[vrcw_pkg::AXIS_X] < side[vrcw_pkg::AXIS_Y] &&
                    side[vrcw_pkg::AXIS_X] < side[vrcw_pkg::AXIS_Z])
                    ax = vrcw_pkg::AXIS_X;
                else if (side[vrcw_pkg::AXIS_Y] < side[vrcw_pkg::AXIS_Z])
                    ax = vrcw_pkg::AXIS_Y;
                else
                    ax = vrcw_pkg::AXIS_Z;
                walk_pos[ax] = step_down[ax] ? walk_pos[ax] - 16'd1 : walk_pos[ax] + 16'd1;
                sum = {1'b0, side[ax]} + {1'b0, delta[ax]};
                side[ax] = sum[32] ? vrcw_pkg::SAT32 : sum[31:0];
                count++;
                rec.x = walk_pos[vrcw_pkg::AXIS_X];
                rec.y = walk_pos[vrcw_pkg::AXIS_Y];
                rec.z = walk_pos[vrcw_pkg::AXIS_Z];
                rec.last = !walk_open(side, count);
                rec.none = 1'b0;
                cells_due.push_back(rec);
            end
        end
    endtask

    task automatic send_ray(input logic [vrcw_pkg::EYE_W-1:0] ex,
                            input logic [vrcw_pkg::EYE_W-1:0] ey,
                            input logic [vrcw_pkg::EYE_W-1:0] ez,
                            input logic [vrcw_pkg::DIR_W-1:0] dx,
                            input logic [vrcw_pkg::DIR_W-1:0] dy,
                            input logic [vrcw_pkg::DIR_W-1:0] dz);
        logic [2:0][vrcw_pkg::EYE_W-1:0] eye;
        logic [2:0][vrcw_pkg::DIR_W-1:0] dir;
        eye = {ez, ey, ex};
        dir = {dz, dy, dx};
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tdata  <= {dir, eye};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        predict_walk(eye, dir);
    endtask

    task automatic stop_rays();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_cells_done();
        while (cells_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [vrcw_pkg::PADDR_W-1:0] addr,
                             input logic [vrcw_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_REACH) reach_cfg = data[vrcw_pkg::REACH_W-1:0];
    endtask

    task automatic check_reach_readback();
        logic [vrcw_pkg::PDATA_W-1:0] data;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_REACH;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data !== {16'd0, reach_cfg})
            report_mismatch("reach readback", data, 32'(reach_cfg));
    endtask

    task automatic set_reach(input logic [vrcw_pkg::REACH_W-1:0] value);
        stop_rays();
        wait_cells_done();
        apb_write(REG_REACH, {16'd0, value});
        check_reach_readback();
    endtask

    task automatic random_ray();
        logic [2:0][vrcw_pkg::EYE_W-1:0] eye;
        logic [2:0][vrcw_pkg::DIR_W-1:0] dir;
        int                              mode;
        for (int a = 0; a < vrcw_pkg::NUM_AXES; a++) begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
                eye[a] = $urandom;
            else if (mode < 8)
                eye[a] = {16'($urandom_range(0, 6) - 3), 16'($urandom)};
            else if (mode == 8)
                eye[a] = {16'($urandom), 16'h0000};
            else
                eye[a] = {16'($urandom), 16'hFFFF};
        end
        mode = $urandom_range(0, 19);
        for (int a = 0; a < vrcw_pkg::NUM_AXES; a++) begin
            if (mode < 12)
                dir[a] = 16'($urandom_range(0, 32768) - 16384);
            else if (mode < 15)
                dir[a] = ($urandom_range(0, 2) == 0) ? 16'd0
                                                     : 16'($urandom_range(0, 32768) - 16384);
            else if (mode < 17)
                dir[a] = 16'($urandom);
            else if (mode < 19)
                dir[a] = ($urandom_range(0, 1) == 0) ? 16'd9459 : 16'hDB0D;
            else
                dir[a] = (a == $urandom_range(0, 2)) ? 16'($urandom_range(0, 1) ? 16384 : -16384)
                                                     : 16'd0;
        end
        send_ray(eye[0], eye[1], eye[2], dir[0], dir[1], dir[2]);
    endtask

    // cell stream checker
    always @(posedge i_clk) begin
        t_cell_rec want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (cells_due.size() == 0) begin
                report_mismatch("cell request with none due", {16'd0, m_tdata[15:0]}, 32'd0);
            end else begin
                want = cells_due.pop_front();
                if (m_tdata[15:0] !== want.x)
                    report_mismatch("cell_x", 32'(m_tdata[15:0]), 32'(want.x));
                if (m_tdata[31:16] !== want.y)
                    report_mismatch("cell_y", 32'(m_tdata[31:16]), 32'(want.y));
                if (m_tdata[47:32] !== want.z)
                    report_mismatch("cell_z", 32'(m_tdata[47:32]), 32'(want.z));
                if (m_tlast !== want.last)
                    report_mismatch("last_cell", 32'(m_tlast), 32'(want.last));
                if (m_tuser !== want.none)
                    report_mismatch("no_cell", 32'(m_tuser), 32'(want.none));
            end
        end
    end

    // output backpressure
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_reset_value();
        check_reach_readback();
    endtask

    task automatic test_directed_rays();
        send_ray(32'h0001_8000, 32'h0000_4000, 32'h0000_C000, 16'd16384, 16'd0, 16'd0);
        send_ray(32'h0001_8000, 32'h0000_4000, 32'h0000_C000, 16'hC000, 16'd0, 16'd0);
        send_ray(32'h0000_2000, 32'h0003_1000, 32'h0000_0000, 16'd0, 16'd16384, 16'd0);
        send_ray(32'h0000_2000, 32'h0003_1000, 32'h0000_0000, 16'd0, 16'hC000, 16'd0);
        send_ray(32'hFFFF_8000, 32'h0000_0000, 32'h0002_7000, 16'd0, 16'd0, 16'd16384);
        send_ray(32'hFFFF_8000, 32'h0000_0000, 32'h0002_7000, 16'd0, 16'd0, 16'hC000);
        // zero direction, nothing in reach
        send_ray(32'h0001_2345, 32'h0002_3456, 32'h0003_4567, 16'd0, 16'd0, 16'd0);
        send_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'h8000, 16'd0, 16'd0);
        // three-way tie from a grid corner
        send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd9459, 16'd9459, 16'd9459);
        send_ray(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 16'd11585, 16'd11585, 16'd0);
        // coordinate wrap both ways
        send_ray(32'h7FFF_8000, 32'h0000_0000, 32'h0000_0000, 16'd16384, 16'd0, 16'd0);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hC000, 16'd0, 16'd0);
        send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd9459, 16'd9459, 16'd9459);
        send_ray(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 16'h7FFF, 16'd0, 16'd0);
        send_ray(32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd1, 16'd0, 16'd0);
        send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hF000, 16'hE000, 16'hD000);
    endtask

    task automatic test_reach_extremes();
        set_reach(16'd0);
        send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hC000, 16'd0, 16'd0);
        send_ray(32'h0001_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd16384, 16'd0, 16'd0);
        set_reach(16'hFFFF);
        send_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'd9459, 16'hDB0D, 16'd9459);
        send_ray(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 16'd0, 16'd16384, 16'd0);
        set_reach(16'd1);
        send_ray(32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd16384, 16'd0, 16'd0);
        send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd0, 16'hC000, 16'd0);
        // write beyond the only register is dropped
        stop_rays();
        wait_cells_done();
        apb_write(REG_SPARE, 32'h0000_0005);
        check_reach_readback();
        send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd0, 16'd0, 16'hC000);
        set_reach(vrcw_pkg::REACH_RESET);
    endtask

    task automatic test_random_rays();
        logic [vrcw_pkg::REACH_W-1:0] reach_plan [5];
        reach_plan = '{vrcw_pkg::REACH_RESET, 16'($urandom), 16'hFFFF, 16'd512,
                       16'($urandom_range(0, 4096))};
        for (int p = 0; p < 5; p++) begin
            set_reach(reach_plan[p]);
            for (int n = 0; n < 80; n++) begin
                random_ray();
                if (p == 1 && n == 40) begin
                    stop_rays();
                    wait_cells_done();
                end
            end
        end
    endtask

    task automatic test_streaming_rays();
        set_reach(16'd3000);
        idle_on = 1'b0;
        repeat (60) random_ray();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        s_tdata    = '0;
        s_tvalid   = 1'b0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        reach_cfg  = vrcw_pkg::REACH_RESET;
        idle_on    = 1'b1;
        fail_count = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_value();
        test_directed_rays();
        test_reach_extremes();
        test_random_rays();
        test_streaming_rays();

        stop_rays();
        for (int c = 0; c < 5000 && cells_due.size() != 0; c++) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (cells_due.size() != 0) report_mismatch("cells never sent", cells_due.size(), 0);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/vrcw_pkg.sv
rtl/core/voxel_ray_cell_walker_core.sv
test/tb_voxel_ray_cell_walker_core.sv
